[rtl/apu_pkg.sv]
// Shared types, constants and saturation helpers for the Adam parameter update block.
`timescale 1ns / 1ps
package apu_pkg;

   localparam int unsigned STORE_DEPTH_DEF = 1024;

   localparam logic [24:0] ONE_Q24     = 25'h100_0000;
   localparam logic [23:0] LR_RESET    = 24'd16777;
   localparam logic [23:0] BETA1_RESET = 24'd15099494;
   localparam logic [23:0] BETA2_RESET = 24'd16760438;
   localparam logic [31:0] EPS_RESET   = 32'd43;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_APPLY = 2'd1,
      OP_PASS  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_LR    = 3'd0,
      CSR_BETA1 = 3'd1,
      CSR_BETA2 = 3'd2,
      CSR_EPS   = 3'd3,
      CSR_NEST  = 3'd4
   } csr_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [9:0]         entry_index;
      logic signed [31:0] gradient;
      logic signed [31:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weight_out;
      logic signed [31:0] moment1_out;
      logic [31:0]        moment2_out;
   } rsp_type;

   typedef struct packed {
      logic        go;
      logic        sqrt_mode;
      logic [5:0]  count;
      logic [36:0] rem_init;
      logic [55:0] num_init;
      logic [36:0] divisor;
   } iter_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PASS_B1,
      ST_PASS_B2,
      ST_PASS_END,
      ST_READ,
      ST_M_B1,
      ST_M_G,
      ST_M_GG,
      ST_M_FIN,
      ST_V_LO,
      ST_V_HI,
      ST_V_ACC,
      ST_V_FIN,
      ST_N_FIN,
      ST_SQ_ALPHA,
      ST_LR_MUL,
      ST_LR_PROD,
      ST_DIV_ALPHA,
      ST_SQ_DEN,
      ST_DEN,
      ST_MAG,
      ST_DIV_STEP,
      ST_WRITE,
      ST_FIN
   } state_type;

   function automatic logic [31:0] sat_s32(input logic signed [66:0] x);
      logic [31:0] r;
      if (x > 67'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -67'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_u32(input logic [66:0] x);
      logic [31:0] r;
      if (x[66:32] != 35'd0) begin
         r = 32'hFFFF_FFFF;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/apu_iter.sv]
// Shared iterative unit: restoring divide (one quotient bit a cycle) or square root (one root bit a cycle).
`timescale 1ns / 1ps
module apu_iter import apu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  iter_cmd_type cmd,
   output logic         busy,
   output logic [39:0]  quotient,
   output logic [27:0]  root
);

   logic [5:0]  cnt_ff;
   logic [5:0]  cnt_in;
   logic        mode_ff;
   logic [36:0] rem_ff;
   logic [36:0] rem_in;
   logic [55:0] num_ff;
   logic [55:0] num_in;
   logic [36:0] div_ff;
   logic [27:0] root_ff;
   logic [27:0] root_in;

   logic [37:0] dtrial;
   logic        dge;
   logic [31:0] strial;
   logic [29:0] sbase;
   logic        sge;

   always_comb begin
      dtrial = {rem_ff, num_ff[55]};
      dge    = dtrial >= {1'b0, div_ff};
      strial = {rem_ff[29:0], num_ff[55:54]};
      sbase  = {root_ff, 2'b01};
      sge    = strial >= {2'b00, sbase};
      rem_in  = rem_ff;
      num_in  = num_ff;
      root_in = root_ff;
      if (mode_ff) begin
         root_in = {root_ff[26:0], sge};
         rem_in  = sge ? 37'(strial - {2'b00, sbase}) : 37'(strial);
         num_in  = {num_ff[53:0], 2'b00};
      end else begin
         rem_in = dge ? 37'(dtrial - {1'b0, div_ff}) : dtrial[36:0];
         num_in = {num_ff[54:0], dge};
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.go) begin
         cnt_in = cmd.count;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         mode_ff <= cmd.sqrt_mode;
         rem_ff  <= cmd.rem_init;
         num_ff  <= cmd.num_init;
         div_ff  <= cmd.divisor;
         root_ff <= 28'd0;
      end else if (cnt_ff != 6'd0) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         root_ff <= root_in;
      end
   end

   assign busy     = cnt_ff != 6'd0;
   assign quotient = num_ff[39:0];
   assign root     = root_ff;

   a_go_idle: assert property (@(posedge clock) disable iff (reset) cmd.go |-> !busy)
      else $error("iterative unit restarted while busy");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.go && !cmd.sqrt_mode) |-> (cmd.divisor != 37'd0))
      else $error("divide started with zero divisor");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> (cnt_ff <= 6'd40))
      else $error("iteration count out of range");

endmodule

[rtl/adam_parameter_update.sv]
// Top level of the Adam parameter update block: sequencer, shared multiplier, store and channels.
`timescale 1ns / 1ps
// One item at a time. A load passes through ST_LOAD and ST_FIN before rsp_valid rises, an end
// of pass through ST_PASS_B1, ST_PASS_B2, ST_PASS_END and ST_FIN, and an undefined op or an
// out-of-range index through ST_FIN only. An apply does the store read and seven passes through
// the shared 33x33 multiplier first. The iterative unit then runs four jobs, one bit a cycle
// each: a 28-step square root and a 32-step divide for the bias-corrected step size, a 28-step
// square root of the second moment, and a 40-step divide of the step; a further multiplier
// pass comes before each divide, nine in all. A saturated step size skips its divide, and so
// does a saturated step. The input stalls from accept until the result is loaded into the output
// register; a result may wait there while the next item is already at work.
module adam_parameter_update import apu_pkg::*; #(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   state_type state_ff, state_in;

   logic [23:0] lr_ff, beta1_ff, beta2_ff;
   logic [31:0] eps_ff;
   logic        nest_ff;
   logic [23:0] acc1_ff, acc2_ff;

   req_type     item_ff;
   rsp_type     res_ff;
   rsp_type     rsp_data_ff;
   logic        rsp_valid_ff;

   logic [31:0] mem_w [STORE_DEPTH];
   logic [31:0] mem_m [STORE_DEPTH];
   logic [31:0] mem_v [STORE_DEPTH];
   logic [31:0] rd_w_ff, rd_m_ff, rd_v_ff;
   logic [AW+9:0] idx_ext;
   logic [AW-1:0] addr;
   logic        mem_we;
   logic [31:0] wd_w, wd_m, wd_v;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;
   logic signed [66:0] acc_ff;
   logic signed [65:0] gc_ff;
   logic [38:0] g2_ff;
   logic [31:0] m_new_ff, v_new_ff, n_ff, alpha_ff;
   logic [36:0] den_ff;
   logic [40:0] step_ff;

   iter_cmd_type cmd;
   logic         it_busy;
   logic [39:0]  it_quo;
   logic [27:0]  it_root;

   logic        accept, in_range, fin_load;
   logic [24:0] c1, c2, d1, d2;
   logic [71:0] cmp_num, cmp_div;
   logic        ovf;
   logic [36:0] den_sum, den_calc;
   logic        n_neg;
   logic signed [32:0] n_abs;
   logic signed [42:0] w_sum;
   logic [31:0] w_calc;

   apu_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .busy     (it_busy),
      .quotient (it_quo),
      .root     (it_root)
   );

   assign accept   = req_valid && !req_stall;
   assign in_range = {22'd0, req_data.entry_index} < 32'(STORE_DEPTH);
   assign fin_load = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign idx_ext  = (AW + 10)'(item_ff.entry_index);
   assign addr     = idx_ext[AW-1:0];

   assign c1 = ONE_Q24 - {1'b0, beta1_ff};
   assign c2 = ONE_Q24 - {1'b0, beta2_ff};
   assign d1 = ONE_Q24 - {1'b0, acc1_ff};
   assign d2 = ONE_Q24 - {1'b0, acc2_ff};

   always_comb begin
      den_sum  = {1'b0, it_root, 8'h00} + {5'd0, eps_ff};
      den_calc = (den_sum == 37'd0) ? 37'd1 : den_sum;
      n_neg    = n_ff[31];
      n_abs    = n_neg ? -{n_ff[31], n_ff} : {n_ff[31], n_ff};
      w_sum    = n_neg ? ({{11{rd_w_ff[31]}}, rd_w_ff} + {2'b00, step_ff})
                       : ({{11{rd_w_ff[31]}}, rd_w_ff} - {2'b00, step_ff});
      w_calc   = sat_s32({{24{w_sum[42]}}, w_sum});
   end

   // overflow compare ahead of each divide: quotient would not fit
   always_comb begin
      cmp_num = 72'd0;
      cmp_div = 72'd1;
      if (state_ff == ST_LR_PROD) begin
         cmp_num = 72'(prod_ff[48:0]);
         cmp_div = 72'({d1, 32'h0});
      end else if (state_ff == ST_MAG) begin
         cmp_num = 72'(prod_ff[63:0]);
         cmp_div = 72'({den_ff, 32'h0});
      end
      ovf = cmp_num >= cmp_div;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_LOAD:  state_in = in_range ? ST_LOAD : ST_FIN;
                  OP_APPLY: state_in = in_range ? ST_READ : ST_FIN;
                  OP_PASS:  state_in = ST_PASS_B1;
                  default:  state_in = ST_FIN;
               endcase
            end
         end
         ST_LOAD:      state_in = ST_FIN;
         ST_PASS_B1:   state_in = ST_PASS_B2;
         ST_PASS_B2:   state_in = ST_PASS_END;
         ST_PASS_END:  state_in = ST_FIN;
         ST_READ:      state_in = ST_M_B1;
         ST_M_B1:      state_in = ST_M_G;
         ST_M_G:       state_in = ST_M_GG;
         ST_M_GG:      state_in = ST_M_FIN;
         ST_M_FIN:     state_in = ST_V_LO;
         ST_V_LO:      state_in = ST_V_HI;
         ST_V_HI:      state_in = ST_V_ACC;
         ST_V_ACC:     state_in = ST_V_FIN;
         ST_V_FIN:     state_in = ST_N_FIN;
         ST_N_FIN:     state_in = ST_SQ_ALPHA;
         ST_SQ_ALPHA:  state_in = it_busy ? ST_SQ_ALPHA : ST_LR_MUL;
         ST_LR_MUL:    state_in = ST_LR_PROD;
         ST_LR_PROD:   state_in = ovf ? ST_SQ_DEN : ST_DIV_ALPHA;
         ST_DIV_ALPHA: state_in = it_busy ? ST_DIV_ALPHA : ST_SQ_DEN;
         ST_SQ_DEN:    state_in = it_busy ? ST_SQ_DEN : ST_DEN;
         ST_DEN:       state_in = ST_MAG;
         ST_MAG:       state_in = ovf ? ST_WRITE : ST_DIV_STEP;
         ST_DIV_STEP:  state_in = it_busy ? ST_DIV_STEP : ST_WRITE;
         ST_WRITE:     state_in = ST_FIN;
         ST_FIN:       state_in = fin_load ? ST_IDLE : ST_FIN;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operands, iterative unit commands, store writes
   always_comb begin
      mul_a     = 33'sd0;
      mul_b     = 33'sd0;
      cmd       = '0;
      mem_we    = 1'b0;
      wd_w      = w_calc;
      wd_m      = m_new_ff;
      wd_v      = v_new_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_LOAD: begin
            mem_we = 1'b1;
            wd_w   = item_ff.load_value;
            wd_m   = 32'd0;
            wd_v   = 32'd0;
         end
         ST_PASS_B1: begin
            mul_a = {9'd0, acc1_ff};
            mul_b = {9'd0, beta1_ff};
         end
         ST_PASS_B2: begin
            mul_a = {9'd0, acc2_ff};
            mul_b = {9'd0, beta2_ff};
         end
         ST_M_B1: begin
            mul_a = {rd_m_ff[31], rd_m_ff};
            mul_b = {9'd0, beta1_ff};
         end
         ST_M_G: begin
            mul_a = {item_ff.gradient[31], item_ff.gradient};
            mul_b = {8'd0, c1};
         end
         ST_M_GG: begin
            mul_a = {item_ff.gradient[31], item_ff.gradient};
            mul_b = {item_ff.gradient[31], item_ff.gradient};
         end
         ST_M_FIN: begin
            mul_a = {1'b0, rd_v_ff};
            mul_b = {9'd0, beta2_ff};
         end
         ST_V_LO: begin
            mul_a = {1'b0, g2_ff[31:0]};
            mul_b = {8'd0, c2};
         end
         ST_V_HI: begin
            mul_a = {26'd0, g2_ff[38:32]};
            mul_b = {8'd0, c2};
         end
         ST_V_ACC: begin
            mul_a = {m_new_ff[31], m_new_ff};
            mul_b = {9'd0, beta1_ff};
         end
         ST_N_FIN: begin
            cmd.go        = 1'b1;
            cmd.sqrt_mode = 1'b1;
            cmd.count     = 6'd28;
            cmd.num_init  = {7'd0, d2, 24'h0};
         end
         ST_LR_MUL: begin
            mul_a = {9'd0, lr_ff};
            mul_b = {8'd0, it_root[24:0]};
         end
         ST_LR_PROD: begin
            cmd.go = 1'b1;
            if (ovf) begin
               cmd.sqrt_mode = 1'b1;
               cmd.count     = 6'd28;
               cmd.num_init  = {v_new_ff, 24'h0};
            end else begin
               cmd.count    = 6'd32;
               cmd.rem_init = 37'(prod_ff[48:32]);
               cmd.num_init = {prod_ff[31:0], 24'h0};
               cmd.divisor  = 37'(d1);
            end
         end
         ST_DIV_ALPHA: begin
            if (!it_busy) begin
               cmd.go        = 1'b1;
               cmd.sqrt_mode = 1'b1;
               cmd.count     = 6'd28;
               cmd.num_init  = {v_new_ff, 24'h0};
            end
         end
         ST_DEN: begin
            mul_a = n_abs;
            mul_b = {1'b0, alpha_ff};
         end
         ST_MAG: begin
            if (!ovf) begin
               cmd.go       = 1'b1;
               cmd.count    = 6'd40;
               cmd.rem_init = 37'(prod_ff[63:32]);
               cmd.num_init = {prod_ff[31:0], 24'h0};
               cmd.divisor  = den_ff;
            end
         end
         ST_WRITE: mem_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= LR_RESET;
         beta1_ff <= BETA1_RESET;
         beta2_ff <= BETA2_RESET;
         eps_ff   <= EPS_RESET;
         nest_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LR:    lr_ff    <= csr_wdata[23:0];
            CSR_BETA1: beta1_ff <= csr_wdata[23:0];
            CSR_BETA2: beta2_ff <= csr_wdata[23:0];
            CSR_EPS:   eps_ff   <= csr_wdata;
            CSR_NEST:  nest_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc1_ff <= BETA1_RESET;
         acc2_ff <= BETA2_RESET;
      end else if (state_ff == ST_PASS_B2) begin
         acc1_ff <= prod_ff[47:24];
      end else if (state_ff == ST_PASS_END) begin
         acc2_ff <= prod_ff[47:24];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_w[addr] <= wd_w;
         mem_m[addr] <= wd_m;
         mem_v[addr] <= wd_v;
      end
      if (state_ff == ST_READ) begin
         rd_w_ff <= mem_w[addr];
         rd_m_ff <= mem_m[addr];
         rd_v_ff <= mem_v[addr];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // datapath registers advanced by the sequencer
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_ff <= req_data;
               res_ff  <= '0;
            end
         end
         ST_LOAD: res_ff.weight_out <= item_ff.load_value;
         ST_M_G:  acc_ff <= {prod_ff[65], prod_ff};
         ST_M_GG: begin
            acc_ff <= acc_ff + {prod_ff[65], prod_ff};
            gc_ff  <= prod_ff;
         end
         ST_M_FIN: begin
            m_new_ff <= sat_s32(acc_ff >>> 24);
            g2_ff    <= prod_ff[62:24];
         end
         ST_V_LO:  acc_ff <= {prod_ff[65], prod_ff};
         ST_V_HI:  acc_ff <= acc_ff + {prod_ff[65], prod_ff};
         ST_V_ACC: acc_ff <= acc_ff + {prod_ff[34:0], 32'h0};
         ST_V_FIN: begin
            v_new_ff <= sat_u32(acc_ff >>> 24);
            acc_ff   <= {gc_ff[65], gc_ff} + {prod_ff[65], prod_ff};
         end
         ST_N_FIN: n_ff <= nest_ff ? sat_s32(acc_ff >>> 24) : m_new_ff;
         ST_LR_PROD: begin
            if (ovf) begin
               alpha_ff <= 32'hFFFF_FFFF;
            end
         end
         ST_DIV_ALPHA: begin
            if (!it_busy) begin
               alpha_ff <= it_quo[31:0];
            end
         end
         ST_DEN: den_ff <= den_calc;
         ST_MAG: begin
            if (ovf) begin
               step_ff <= 41'h100_0000_0000;
            end
         end
         ST_DIV_STEP: begin
            if (!it_busy) begin
               step_ff <= {1'b0, it_quo};
            end
         end
         ST_WRITE: begin
            res_ff.weight_out  <= w_calc;
            res_ff.moment1_out <= m_new_ff;
            res_ff.moment2_out <= v_new_ff;
         end
         default: ;
      endcase
   end

   // output register: hold the beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FIN))
      else $error("result beat raised outside finish");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (step_ff <= 41'h100_0000_0000))
      else $error("weight step above saturation limit");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAG) |-> (den_ff != 37'd0))
      else $error("zero denominator reached the step divide");

endmodule
